>>> sv/dshot_throttle_transmitter_top_macros.svh
// Assertion helpers shared by the transmitter RTL.
`ifndef DSHOT_THROTTLE_TRANSMITTER_TOP_MACROS_SVH
`define DSHOT_THROTTLE_TRANSMITTER_TOP_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define DSHOT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define DSHOT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dshot_pkg.sv
package dshot_pkg;

  localparam int ARM_COUNT_BITS = 16;
  localparam int CFG_DATA_W = 16;

  localparam logic [10:0] THR_LIMIT = 11'd2000;
  localparam logic [10:0] MAP_BASE = 11'd48;
  localparam logic [10:0] MAP_BASE_M1 = 11'd47;

  localparam logic [10:0] MAX_THROTTLE_RST = 11'd1000;
  localparam logic [10:0] STEP_LIMIT_RST = 11'd1;
  localparam logic [15:0] ARM_FRAMES_RST = 16'd3000;
  localparam logic [7:0] ONE_HIGH_RST = 8'd12;
  localparam logic [7:0] ONE_LOW_RST = 8'd5;
  localparam logic [7:0] ZERO_HIGH_RST = 8'd6;
  localparam logic [7:0] ZERO_LOW_RST = 8'd11;

  typedef enum logic [1:0] {
    MODE_THROTTLE = 2'd0,
    MODE_STOP = 2'd1,
    MODE_TICK = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CFG_MAX_THROTTLE = 3'd0,
    CFG_STEP_LIMIT = 3'd1,
    CFG_ARM_FRAMES = 3'd2,
    CFG_REQ_TELEMETRY = 3'd3,
    CFG_ONE_HIGH = 3'd4,
    CFG_ONE_LOW = 3'd5,
    CFG_ZERO_HIGH = 3'd6,
    CFG_ZERO_LOW = 3'd7
  } cfg_index_t;

  typedef struct packed {
    mode_t mode;
    logic signed [31:0] command_value;
    logic stop_value;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] high_ticks;
    logic [7:0] low_ticks;
    logic bit_value;
    logic last_bit;
    logic [15:0] frame_word;
    logic armed;
    logic [10:0] current_throttle;
  } out_beat_t;

  function automatic logic [ARM_COUNT_BITS-1:0] arm_limit(input logic [15:0] frames);
    logic [63:0] top;
    logic [63:0] req;
    top = (64'd1 << ARM_COUNT_BITS) - 64'd1;
    req = 64'(frames);
    return ARM_COUNT_BITS'((req > top) ? top : req);
  endfunction

  // v*1999/2000 truncated is v-1 for v in 1..2000 and 0 for v = 0
  function automatic logic [15:0] frame_build(input logic [10:0] used, input logic tlm);
    logic [10:0] value;
    logic [11:0] upper;
    logic [3:0] csum;
    value = (used == 11'd0) ? MAP_BASE : used + MAP_BASE_M1;
    upper = {value, tlm};
    csum = upper[3:0] ^ upper[7:4] ^ upper[11:8];
    return {upper, csum};
  endfunction

endpackage

>>> sv/dshot_throttle_transmitter_top.sv
// An accepted frame tick waits in the pending register until the frame buffer is free;
//   its sixteen symbols then pass from the buffer into the output register in order.
// Throughput: the serializer sends one symbol per cycle while the output is not stalled;
//   one more frame tick can pend meanwhile; throttle and stop beats are taken every cycle.
// Reset (synchronous): restores register defaults and clears throttle, arming and
//   serializer state; no clearing pass.
`include "dshot_throttle_transmitter_top_macros.svh"

module dshot_throttle_transmitter_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  dshot_pkg::in_beat_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output dshot_pkg::out_beat_t             out_data,
  input  logic                             cfg_write,
  input  dshot_pkg::cfg_index_t            cfg_index,
  input  logic [dshot_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dshot_pkg::*;

  logic [10:0] max_throttle;
  logic [10:0] step_limit;
  logic [15:0] arm_frames;
  logic        request_telemetry;
  logic [7:0]  one_high_ticks;
  logic [7:0]  one_low_ticks;
  logic [7:0]  zero_high_ticks;
  logic [7:0]  zero_low_ticks;

  logic [10:0]               target_throttle, target_throttle_next;
  logic                      stop_latched, stop_latched_next;
  logic [10:0]               ramped_throttle, ramped_throttle_next;
  logic [ARM_COUNT_BITS-1:0] arm_count, arm_count_next;
  logic                      armed_flag, armed_flag_next;

  logic        pend, pend_next;
  logic [10:0] pend_used, pend_used_next;
  logic        pend_armed, pend_armed_next;

  logic        buf_busy;
  logic [3:0]  buf_idx;
  logic [15:0] buf_frame;
  logic        buf_armed;
  logic [10:0] buf_used;

  logic accept, is_tick, sym_load, xfer, sym_bit;
  logic [ARM_COUNT_BITS-1:0] limit, count_inc;
  logic        armed_now;
  logic [10:0] cap, goal, ramp_val;

  assign is_tick  = (in_data.mode == MODE_TICK);
  assign in_stall = pend && is_tick;
  assign accept   = in_valid && !in_stall;
  assign sym_load = buf_busy && (!out_valid || !out_stall);
  assign xfer     = pend && (!buf_busy || (sym_load && buf_idx == 4'hF));
  assign sym_bit  = buf_frame[~buf_idx];

  assign limit     = arm_limit(arm_frames);
  assign count_inc = arm_count + ARM_COUNT_BITS'(1);
  assign armed_now = armed_flag || (arm_count >= limit);
  assign cap       = (max_throttle > THR_LIMIT) ? THR_LIMIT : max_throttle;
  assign goal      = stop_latched ? 11'd0 : target_throttle;

  always_comb begin
    ramp_val = ramped_throttle;
    if (ramped_throttle < goal) begin
      ramp_val = ((goal - ramped_throttle) > step_limit) ? ramped_throttle + step_limit : goal;
    end else if (ramped_throttle > goal) begin
      ramp_val = ((ramped_throttle - goal) > step_limit) ? ramped_throttle - step_limit : goal;
    end
  end

  always_comb begin
    target_throttle_next = target_throttle;
    stop_latched_next    = stop_latched;
    ramped_throttle_next = ramped_throttle;
    arm_count_next       = arm_count;
    armed_flag_next      = armed_flag;
    pend_next            = pend && !xfer;
    pend_used_next       = pend_used;
    pend_armed_next      = pend_armed;
    if (accept) begin
      unique case (in_data.mode)
        MODE_THROTTLE: begin
          if (in_data.command_value[31]) begin
            target_throttle_next = 11'd0;
          end else if (unsigned'(in_data.command_value) > 32'(cap)) begin
            target_throttle_next = cap;
          end else begin
            target_throttle_next = in_data.command_value[10:0];
          end
        end
        MODE_STOP: begin
          stop_latched_next = in_data.stop_value;
          if (in_data.stop_value) begin
            target_throttle_next = 11'd0;
          end
        end
        MODE_TICK: begin
          pend_next = 1'b1;
          if (armed_now) begin
            ramped_throttle_next = ramp_val;
            armed_flag_next      = 1'b1;
            pend_used_next       = ramp_val;
            pend_armed_next      = 1'b1;
          end else begin
            arm_count_next  = count_inc;
            armed_flag_next = (count_inc >= limit);
            pend_used_next  = 11'd0;
            pend_armed_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_throttle      <= MAX_THROTTLE_RST;
      step_limit        <= STEP_LIMIT_RST;
      arm_frames        <= ARM_FRAMES_RST;
      request_telemetry <= 1'b0;
      one_high_ticks    <= ONE_HIGH_RST;
      one_low_ticks     <= ONE_LOW_RST;
      zero_high_ticks   <= ZERO_HIGH_RST;
      zero_low_ticks    <= ZERO_LOW_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MAX_THROTTLE:  max_throttle      <= cfg_data[10:0];
        CFG_STEP_LIMIT:    step_limit        <= cfg_data[10:0];
        CFG_ARM_FRAMES:    arm_frames        <= cfg_data[15:0];
        CFG_REQ_TELEMETRY: request_telemetry <= cfg_data[0];
        CFG_ONE_HIGH:      one_high_ticks    <= cfg_data[7:0];
        CFG_ONE_LOW:       one_low_ticks     <= cfg_data[7:0];
        CFG_ZERO_HIGH:     zero_high_ticks   <= cfg_data[7:0];
        CFG_ZERO_LOW:      zero_low_ticks    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_throttle <= '0;
      stop_latched    <= 1'b0;
      ramped_throttle <= '0;
      arm_count       <= '0;
      armed_flag      <= 1'b0;
      pend            <= 1'b0;
    end else begin
      target_throttle <= target_throttle_next;
      stop_latched    <= stop_latched_next;
      ramped_throttle <= ramped_throttle_next;
      arm_count       <= arm_count_next;
      armed_flag      <= armed_flag_next;
      pend            <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_used  <= pend_used_next;
    pend_armed <= pend_armed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_busy <= 1'b0;
      buf_idx  <= '0;
    end else if (xfer) begin
      buf_busy <= 1'b1;
      buf_idx  <= '0;
    end else if (sym_load) begin
      buf_busy <= (buf_idx != 4'hF);
      buf_idx  <= buf_idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      buf_frame <= frame_build(pend_used, request_telemetry);
      buf_armed <= pend_armed;
      buf_used  <= pend_used;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sym_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_load) begin
      out_data.high_ticks       <= sym_bit ? one_high_ticks : zero_high_ticks;
      out_data.low_ticks        <= sym_bit ? one_low_ticks : zero_low_ticks;
      out_data.bit_value        <= sym_bit;
      out_data.last_bit         <= (buf_idx == 4'hF);
      out_data.frame_word       <= buf_frame;
      out_data.armed            <= buf_armed;
      out_data.current_throttle <= buf_used;
    end
  end

  `DSHOT_ASSERT_NEXT(a_tick_pends, accept && is_tick, pend, "accepted tick did not pend")
  `DSHOT_ASSERT_NEXT(a_armed_sticks, armed_flag, armed_flag, "armed flag dropped")
  `DSHOT_ASSERT_NOW(a_idx_busy, buf_idx != 4'd0, buf_busy, "symbol index set while idle")
  `DSHOT_ASSERT_NEXT(a_last_symbol, sym_load && buf_idx == 4'hF,
                     out_valid && out_data.last_bit, "sixteenth symbol not marked last")
  `DSHOT_ASSERT_NOW(a_unarmed_zero, out_valid && !out_data.armed,
                    out_data.current_throttle == 11'd0, "unarmed beat carries throttle")

endmodule
